[design/tga_image_stream_decoder_unit_defines.svh]
// Assertion macros used by the decoder unit.
`ifndef TGA_IMAGE_STREAM_DECODER_UNIT_DEFINES_SVH
`define TGA_IMAGE_STREAM_DECODER_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TISD_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("decoder check failed");

// The consequent must hold in the cycle after the antecedent.
`define TISD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("decoder check failed");

`endif

[design/tisd_pkg.sv]
package tisd_pkg;

  typedef enum logic [5:0] {
    PH_IDLE    = 6'b000001,
    PH_HEADER  = 6'b000010,
    PH_IDSKIP  = 6'b000100,
    PH_PKTHEAD = 6'b001000,
    PH_PIXEL   = 6'b010000,
    PH_DONE    = 6'b100000
  } phase_t;

  typedef enum logic [1:0] {
    KIND_PIXEL  = 2'd0,
    KIND_HEADER = 2'd1,
    KIND_UNSUP  = 2'd2
  } kind_t;

  // Header byte offsets.
  localparam logic [4:0] HDR_ID_LEN    = 5'd0;
  localparam logic [4:0] HDR_TYPE      = 5'd2;
  localparam logic [4:0] HDR_WIDTH_LO  = 5'd12;
  localparam logic [4:0] HDR_WIDTH_HI  = 5'd13;
  localparam logic [4:0] HDR_HEIGHT_LO = 5'd14;
  localparam logic [4:0] HDR_HEIGHT_HI = 5'd15;
  localparam logic [4:0] HDR_DEPTH     = 5'd16;
  localparam logic [4:0] HDR_DESC      = 5'd17;

  localparam logic [7:0] TYPE_RAW_COLOR = 8'd2;
  localparam logic [7:0] TYPE_RAW_GRAY  = 8'd3;
  localparam logic [7:0] TYPE_RLE_COLOR = 8'd10;

  localparam logic [7:0] DEPTH_8  = 8'd8;
  localparam logic [7:0] DEPTH_24 = 8'd24;
  localparam logic [7:0] DEPTH_32 = 8'd32;

  localparam logic [2:0] BPP_NONE = 3'd0;
  localparam logic [2:0] BPP_1    = 3'd1;
  localparam logic [2:0] BPP_3    = 3'd3;
  localparam logic [2:0] BPP_4    = 3'd4;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] pixel_value;
    logic [7:0]  run_count;
    logic        is_last;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic [2:0]  pixel_bytes;
    logic        flip_rows;
    logic        mirror_columns;
  } result_t;

endpackage

[design/tisd_byte_if.sv]
interface tisd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       start_of_file;

  modport source (output valid, output data_byte, output start_of_file, input ready);
  modport sink (input valid, input data_byte, input start_of_file, output ready);
endinterface

[design/tisd_result_if.sv]
interface tisd_result_if
  import tisd_pkg::*;
  ();
  logic        valid;
  logic        ready;
  kind_t       kind;
  logic [31:0] pixel_value;
  logic [7:0]  run_count;
  logic        is_last;
  logic [15:0] image_width;
  logic [15:0] image_height;
  logic [2:0]  pixel_bytes;
  logic        flip_rows;
  logic        mirror_columns;

  modport source (
    output valid, output kind, output pixel_value, output run_count, output is_last,
    output image_width, output image_height, output pixel_bytes, output flip_rows,
    output mirror_columns, input ready
  );
  modport sink (
    input valid, input kind, input pixel_value, input run_count, input is_last,
    input image_width, input image_height, input pixel_bytes, input flip_rows,
    input mirror_columns, output ready
  );
endinterface

[design/tga_image_stream_decoder_unit.sv]
// Channel   Direction  Item
// stream    in         one file byte plus start-of-file mark
// result    out        header status or one pixel with its run count
//
// A byte can be taken on every clock while the result register is not stalled.
// A result sits in the output register until taken; a byte is taken while the
// register is empty or being emptied in the same cycle.
// A result is registered and shows in the cycle after the byte that completes it is taken.
// rst is synchronous and returns the decoder to idle, waiting for a start mark.
`include "tga_image_stream_decoder_unit_defines.svh"

module tga_image_stream_decoder_unit
  import tisd_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  tisd_byte_if.sink     stream,
  tisd_result_if.source result
);

  typedef struct packed {
    phase_t      phase;
    logic [4:0]  header_index;
    logic [7:0]  id_skip_left;
    logic [15:0] width_reg;
    logic [15:0] height_reg;
    logic [2:0]  bpp;
    logic        compressed;
    logic [1:0]  desc_flags;
    logic [31:0] pixels_left;
    logic [7:0]  packet_left;
    logic        packet_is_run;
    logic [23:0] assembly;
    logic [1:0]  byte_in_pixel;
    logic        type_ok;
  } state_t;

  localparam state_t ST_RESET = '{phase: PH_IDLE, default: '0};

  state_t  st;
  state_t  cur;
  state_t  st_next;
  result_t res;
  result_t res_next;
  logic    res_valid;
  logic    emit;
  logic    in_fire;
  logic [7:0]  b;
  logic [7:0]  pkt_count;
  logic [7:0]  pix_count;
  logic [31:0] pix_value;

  function automatic state_t enter_data(state_t s);
    state_t r;
    r = s;
    r.byte_in_pixel = '0;
    r.assembly = '0;
    r.packet_left = '0;
    r.packet_is_run = 1'b0;
    r.phase = s.compressed ? PH_PKTHEAD : PH_PIXEL;
    return r;
  endfunction

  assign stream.ready = !res_valid || result.ready;
  assign in_fire = stream.valid && stream.ready;
  assign b = stream.data_byte;

  always_comb begin
    cur = st;
    if (stream.start_of_file) begin
      cur = '0;
      cur.phase = PH_HEADER;
    end
    st_next = cur;
    emit = 1'b0;
    pkt_count = {1'b0, b[6:0]} + 8'd1;
    pix_count = 8'd1;
    pix_value = '0;
    res_next.kind = KIND_PIXEL;
    res_next.pixel_value = '0;
    res_next.run_count = 8'd1;
    res_next.is_last = 1'b0;
    res_next.pixel_bytes = cur.bpp;

    case (cur.phase)
      PH_HEADER: begin
        case (cur.header_index)
          HDR_ID_LEN: st_next.id_skip_left = b;
          HDR_TYPE: begin
            st_next.type_ok = (b == TYPE_RAW_COLOR) || (b == TYPE_RAW_GRAY) ||
                              (b == TYPE_RLE_COLOR);
            st_next.compressed = (b == TYPE_RLE_COLOR);
          end
          HDR_WIDTH_LO: st_next.width_reg[7:0] = b;
          HDR_WIDTH_HI: st_next.width_reg[15:8] = b;
          HDR_HEIGHT_LO: st_next.height_reg[7:0] = b;
          HDR_HEIGHT_HI: st_next.height_reg[15:8] = b;
          HDR_DEPTH: begin
            if (b == DEPTH_8) begin
              st_next.bpp = BPP_1;
            end else if (b == DEPTH_24) begin
              st_next.bpp = BPP_3;
            end else if (b == DEPTH_32) begin
              st_next.bpp = BPP_4;
            end else begin
              st_next.bpp = BPP_NONE;
            end
          end
          default: ;
        endcase
        if (cur.header_index != HDR_DESC) begin
          st_next.header_index = cur.header_index + 5'd1;
        end else begin
          st_next.desc_flags = {b[5], b[4]};
          emit = 1'b1;
          res_next.pixel_bytes = st_next.bpp;
          if (!st_next.type_ok || st_next.bpp == BPP_NONE) begin
            st_next.phase = PH_IDLE;
            res_next.kind = KIND_UNSUP;
            res_next.pixel_bytes = BPP_NONE;
          end else if (st_next.width_reg == '0 || st_next.height_reg == '0) begin
            st_next.phase = PH_DONE;
            res_next.kind = KIND_HEADER;
            res_next.is_last = 1'b1;
          end else begin
            st_next.pixels_left = {16'd0, st_next.width_reg} * {16'd0, st_next.height_reg};
            res_next.kind = KIND_HEADER;
            if (st_next.id_skip_left != '0) begin
              st_next.phase = PH_IDSKIP;
            end else begin
              st_next = enter_data(st_next);
            end
          end
        end
      end
      PH_IDSKIP: begin
        st_next.id_skip_left = cur.id_skip_left - 8'd1;
        if (st_next.id_skip_left == '0) begin
          st_next = enter_data(st_next);
        end
      end
      PH_PKTHEAD: begin
        if ({24'd0, pkt_count} > cur.pixels_left) begin
          st_next.packet_left = cur.pixels_left[7:0];
        end else begin
          st_next.packet_left = pkt_count;
        end
        st_next.packet_is_run = b[7];
        st_next.byte_in_pixel = '0;
        st_next.assembly = '0;
        st_next.phase = PH_PIXEL;
      end
      PH_PIXEL: begin
        if ({1'b0, cur.byte_in_pixel} + 3'd1 < cur.bpp) begin
          case (cur.byte_in_pixel)
            2'd0: st_next.assembly[7:0] = cur.assembly[7:0] | b;
            2'd1: st_next.assembly[15:8] = cur.assembly[15:8] | b;
            2'd2: st_next.assembly[23:16] = cur.assembly[23:16] | b;
            default: ;
          endcase
          st_next.byte_in_pixel = cur.byte_in_pixel + 2'd1;
        end else begin
          if (cur.bpp == BPP_1) begin
            pix_value = {24'd0, b};
          end else if (cur.bpp == BPP_3) begin
            pix_value = {8'd0, cur.assembly[7:0], cur.assembly[15:8], b};
          end else begin
            pix_value = {b, cur.assembly[7:0], cur.assembly[15:8], cur.assembly[23:16]};
          end
          st_next.byte_in_pixel = '0;
          st_next.assembly = '0;
          if (cur.compressed && cur.packet_is_run) begin
            pix_count = cur.packet_left;
            st_next.packet_left = '0;
          end else if (cur.packet_left != '0) begin
            st_next.packet_left = cur.packet_left - 8'd1;
          end
          st_next.pixels_left = cur.pixels_left - {24'd0, pix_count};
          emit = 1'b1;
          res_next.kind = KIND_PIXEL;
          res_next.pixel_value = pix_value;
          res_next.run_count = pix_count;
          if (st_next.pixels_left == '0) begin
            st_next.phase = PH_DONE;
            res_next.is_last = 1'b1;
          end else if (cur.compressed && st_next.packet_left == '0) begin
            st_next.phase = PH_PKTHEAD;
          end
        end
      end
      default: ;
    endcase

    res_next.image_width = st_next.width_reg;
    res_next.image_height = st_next.height_reg;
    res_next.flip_rows = st_next.desc_flags[1];
    res_next.mirror_columns = st_next.desc_flags[0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_RESET;
      res_valid <= 1'b0;
    end else begin
      if (in_fire) begin
        st <= st_next;
      end
      if (in_fire && emit) begin
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && emit) begin
      res <= res_next;
    end
  end

  assign result.valid = res_valid;
  assign result.kind = res.kind;
  assign result.pixel_value = res.pixel_value;
  assign result.run_count = res.run_count;
  assign result.is_last = res.is_last;
  assign result.image_width = res.image_width;
  assign result.image_height = res.image_height;
  assign result.pixel_bytes = res.pixel_bytes;
  assign result.flip_rows = res.flip_rows;
  assign result.mirror_columns = res.mirror_columns;

  `TISD_ASSERT_NOW(a_stall_blocks_input, clk, rst, res_valid && !result.ready, !stream.ready)
  `TISD_ASSERT_NOW(a_pixel_phase_has_work, clk, rst, st.phase == PH_PIXEL, st.pixels_left != '0)
  `TISD_ASSERT_NEXT(a_last_ends_image, clk, rst, in_fire && emit && res_next.is_last, st.phase == PH_DONE)
  `TISD_ASSERT_NOW(a_pixel_count_nonzero, clk, rst, res_valid && res.kind == KIND_PIXEL, res.run_count != '0)

endmodule
